/* rtl/core/pale_pkg.sv */
// ----------------------------------------------------------------------------
// pale_pkg
// Shared widths, codes and types for the positional array list engine.
// ----------------------------------------------------------------------------
package pale_pkg;

  localparam int unsigned CAPACITY = 64;
  localparam int unsigned DATA_W   = 32;
  localparam int unsigned IDX_W    = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = IDX_W + 1;
  localparam int unsigned OP_W     = 3;
  localparam int unsigned STAT_W   = 2;
  localparam int unsigned MODE_W   = 2;

  typedef logic [DATA_W-1:0] data_t;
  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [CNT_W-1:0]  cnt_t;
  typedef logic [OP_W-1:0]   op_t;
  typedef logic [STAT_W-1:0] stat_t;
  typedef logic [MODE_W-1:0] mode_t;

  // operation codes
  localparam op_t OP_GET    = 3'd0;
  localparam op_t OP_INSERT = 3'd1;
  localparam op_t OP_DELETE = 3'd2;
  localparam op_t OP_LOCATE = 3'd3;
  localparam op_t OP_PRIOR  = 3'd4;
  localparam op_t OP_NEXT   = 3'd5;
  localparam op_t OP_CLEAR  = 3'd6;

  // result status codes
  localparam stat_t STAT_OK        = 2'd0;
  localparam stat_t STAT_BAD_POS   = 2'd1;
  localparam stat_t STAT_NOT_FOUND = 2'd2;
  localparam stat_t STAT_FULL      = 2'd3;

  // match rules
  localparam mode_t CMP_EQUAL = 2'd0;
  localparam mode_t CMP_BELOW = 2'd1;
  localparam mode_t CMP_ABOVE = 2'd2;

  // element store access, one write and one read port
  typedef struct packed {
    logic  wr_en;
    idx_t  wr_addr;
    data_t wr_data;
    logic  rd_en;
    idx_t  rd_addr;
  } mem_req_t;

endpackage

/* rtl/core/pale_in_if.sv */
// ----------------------------------------------------------------------------
// pale_in_if
// Request channel: operation, position and value with valid/ready.
// ----------------------------------------------------------------------------
interface pale_in_if import pale_pkg::*; ();
  logic  valid;
  logic  ready;
  op_t   op;
  cnt_t  position;
  data_t value_in;

  modport source (output valid, output op, output position, output value_in,
                  input ready);
  modport sink   (input valid, input op, input position, input value_in,
                  output ready);
endinterface

/* rtl/core/pale_out_if.sv */
// ----------------------------------------------------------------------------
// pale_out_if
// Result channel: status, value, found position and length with valid/ready.
// ----------------------------------------------------------------------------
interface pale_out_if import pale_pkg::*; ();
  logic  valid;
  logic  ready;
  stat_t status;
  data_t value_out;
  cnt_t  found_position;
  cnt_t  list_length;

  modport source (output valid, output status, output value_out,
                  output found_position, output list_length, input ready);
  modport sink   (input valid, input status, input value_out,
                  input found_position, input list_length, output ready);
endinterface

/* rtl/core/pale_mem.sv */
// ----------------------------------------------------------------------------
// pale_mem
// Element store: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module pale_mem import pale_pkg::*; (
  input  logic     clk_i,
  input  mem_req_t req_i,
  output data_t    rd_data_o
);

  data_t mem_q [CAPACITY];
  data_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (req_i.wr_en) begin
      mem_q[req_i.wr_addr] <= req_i.wr_data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      rd_data_q <= mem_q[req_i.rd_addr];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* rtl/core/pale_cmp.sv */
// ----------------------------------------------------------------------------
// pale_cmp
// Shared key/entry comparator; unused mode falls back to equality.
// ----------------------------------------------------------------------------
module pale_cmp import pale_pkg::*; (
  input  mode_t mode_i,
  input  data_t key_i,
  input  data_t entry_i,
  output logic  hit_o
);

  always_comb begin
    case (mode_i)
      CMP_BELOW: hit_o = key_i < entry_i;
      CMP_ABOVE: hit_o = key_i > entry_i;
      default:   hit_o = key_i == entry_i;
    endcase
  end

endmodule

/* rtl/core/positional_array_list_engine_unit.sv */
// ----------------------------------------------------------------------------
// positional_array_list_engine_unit
// Packed list of up to CAPACITY values with 1-based positions. Each request
// transfer (get, insert, delete, locate, prior, next, clear) yields one result
// transfer carrying status, value, found position and the new length. The
// list lives in a single-port-read RAM and a small sequencer walks it one
// entry per cycle. Get does a single read; insert and delete move the
// entries behind the position; locate, prior and next scan from the head,
// and prior and next then read the neighbor. The request side is ready only
// while the sequencer is idle; a finished result sits in an output register
// so the next request can be taken while it waits. compare_mode may only be
// written while no request is in flight.
// ----------------------------------------------------------------------------
module positional_array_list_engine_unit import pale_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  pale_in_if.sink    in_if,
  pale_out_if.source out_if,
  input  logic  cfg_we_i,
  input  mode_t cfg_wdata_i
);

  // sequencer states
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_DISP   = 3'd1;  // decode and range checks
  localparam logic [2:0] S_RD     = 3'd2;  // single read at addr_q
  localparam logic [2:0] S_CAP    = 3'd3;  // capture read data
  localparam logic [2:0] S_SHUP   = 3'd4;  // insert: move entries up
  localparam logic [2:0] S_SHDN   = 3'd5;  // delete: move entries down
  localparam logic [2:0] S_SCAN   = 3'd6;  // locate / prior / next search
  localparam logic [2:0] S_RESULT = 3'd7;  // hand result to output register

  logic [2:0] state_q, state_d;

  // latched request
  op_t   op_q, op_d;
  cnt_t  pos_q, pos_d;
  data_t val_q, val_d;

  // list state and config
  cnt_t  count_q, count_d;
  mode_t mode_q;

  // walk control
  cnt_t  idx_q, idx_d;       // next entry to read
  idx_t  addr_q, addr_d;     // single read address
  logic  pend_q, pend_d;     // moved entry waiting to be written
  idx_t  waddr_q, waddr_d;
  logic  chk_q, chk_d;       // scan data available for compare
  idx_t  cidx_q, cidx_d;

  // pending result
  stat_t res_stat_q, res_stat_d;
  data_t res_val_q, res_val_d;
  cnt_t  res_fpos_q, res_fpos_d;

  // output register
  logic  out_valid_q, out_valid_d;
  stat_t out_stat_q, out_stat_d;
  data_t out_val_q, out_val_d;
  cnt_t  out_fpos_q, out_fpos_d;
  cnt_t  out_len_q, out_len_d;

  mem_req_t mreq;
  data_t    rdata;
  mode_t    cmp_mode;
  logic     hit;

  cnt_t pos_m1;
  cnt_t count_p1;
  cnt_t cidx_p1;
  logic pos_ok_rd;
  logic pos_ok_ins;

  assign pos_m1     = pos_q - CNT_W'(1);
  assign count_p1   = count_q + CNT_W'(1);
  assign cidx_p1    = {1'b0, cidx_q} + CNT_W'(1);
  assign pos_ok_rd  = (pos_q != '0) && (pos_q <= count_q);
  assign pos_ok_ins = (pos_q != '0) && (pos_q <= count_p1);

  pale_mem u_mem (
    .clk_i     (clk_i),
    .req_i     (mreq),
    .rd_data_o (rdata)
  );

  // locate follows the register; prior/next always look for equality
  assign cmp_mode = (op_q == OP_LOCATE) ? mode_q : CMP_EQUAL;

  pale_cmp u_cmp (
    .mode_i  (cmp_mode),
    .key_i   (val_q),
    .entry_i (rdata),
    .hit_o   (hit)
  );

  assign in_if.ready = (state_q == S_IDLE);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    pos_d       = pos_q;
    val_d       = val_q;
    count_d     = count_q;
    idx_d       = idx_q;
    addr_d      = addr_q;
    pend_d      = pend_q;
    waddr_d     = waddr_q;
    chk_d       = chk_q;
    cidx_d      = cidx_q;
    res_stat_d  = res_stat_q;
    res_val_d   = res_val_q;
    res_fpos_d  = res_fpos_q;
    out_valid_d = out_valid_q && !out_if.ready;
    out_stat_d  = out_stat_q;
    out_val_d   = out_val_q;
    out_fpos_d  = out_fpos_q;
    out_len_d   = out_len_q;
    mreq        = '0;

    case (state_q)
      S_IDLE: begin
        if (in_if.valid) begin
          op_d    = in_if.op;
          pos_d   = in_if.position;
          val_d   = in_if.value_in;
          state_d = S_DISP;
        end
      end

      S_DISP: begin
        res_stat_d = STAT_OK;
        res_val_d  = '0;
        res_fpos_d = '0;
        idx_d      = '0;
        pend_d     = 1'b0;
        chk_d      = 1'b0;
        addr_d     = pos_m1[IDX_W-1:0];
        state_d    = S_RESULT;
        case (op_q)
          OP_GET, OP_DELETE: begin
            if (pos_ok_rd) begin
              state_d = S_RD;
            end else begin
              res_stat_d = STAT_BAD_POS;
            end
          end
          OP_INSERT: begin
            if (!pos_ok_ins) begin
              res_stat_d = STAT_BAD_POS;
            end else if (count_q == CNT_W'(CAPACITY)) begin
              res_stat_d = STAT_FULL;
            end else begin
              idx_d   = count_q;
              state_d = S_SHUP;
            end
          end
          OP_LOCATE, OP_PRIOR, OP_NEXT: begin
            state_d = S_SCAN;
          end
          OP_CLEAR: begin
            count_d = '0;
          end
          default: begin
          end
        endcase
      end

      S_RD: begin
        mreq.rd_en   = 1'b1;
        mreq.rd_addr = addr_q;
        state_d      = S_CAP;
      end

      S_CAP: begin
        res_val_d = rdata;
        if (op_q == OP_DELETE) begin
          idx_d   = pos_q;
          pend_d  = 1'b0;
          state_d = S_SHDN;
        end else begin
          state_d = S_RESULT;
        end
      end

      // entry i-1 read in one cycle, written to i in the next
      S_SHUP: begin
        if (pend_q) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = waddr_q;
          mreq.wr_data = rdata;
        end
        if (idx_q >= pos_q) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = idx_t'(idx_q - CNT_W'(1));
          pend_d       = 1'b1;
          waddr_d      = idx_q[IDX_W-1:0];
          idx_d        = idx_q - CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            mreq.wr_en   = 1'b1;
            mreq.wr_addr = pos_m1[IDX_W-1:0];
            mreq.wr_data = val_q;
            count_d      = count_p1;
            state_d      = S_RESULT;
          end
        end
      end

      // entry i read in one cycle, written to i-1 in the next
      S_SHDN: begin
        if (pend_q) begin
          mreq.wr_en   = 1'b1;
          mreq.wr_addr = waddr_q;
          mreq.wr_data = rdata;
        end
        if (idx_q < count_q) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = idx_q[IDX_W-1:0];
          pend_d       = 1'b1;
          waddr_d      = idx_t'(idx_q - CNT_W'(1));
          idx_d        = idx_q + CNT_W'(1);
        end else begin
          pend_d = 1'b0;
          if (!pend_q) begin
            count_d = count_q - CNT_W'(1);
            state_d = S_RESULT;
          end
        end
      end

      // read one entry per cycle, compare it the cycle after
      S_SCAN: begin
        if (chk_q && hit) begin
          chk_d = 1'b0;
          case (op_q)
            OP_PRIOR: begin
              if (cidx_q == '0) begin
                res_stat_d = STAT_NOT_FOUND;
                state_d    = S_RESULT;
              end else begin
                addr_d  = cidx_q - idx_t'(1);
                state_d = S_RD;
              end
            end
            OP_NEXT: begin
              if (cidx_p1 < count_q) begin
                addr_d  = cidx_p1[IDX_W-1:0];
                state_d = S_RD;
              end else begin
                res_stat_d = STAT_NOT_FOUND;
                state_d    = S_RESULT;
              end
            end
            default: begin
              res_fpos_d = cidx_p1;
              state_d    = S_RESULT;
            end
          endcase
        end else if (idx_q < count_q) begin
          mreq.rd_en   = 1'b1;
          mreq.rd_addr = idx_q[IDX_W-1:0];
          chk_d        = 1'b1;
          cidx_d       = idx_q[IDX_W-1:0];
          idx_d        = idx_q + CNT_W'(1);
        end else begin
          chk_d = 1'b0;
          if (!chk_q) begin
            res_stat_d = STAT_NOT_FOUND;
            state_d    = S_RESULT;
          end
        end
      end

      S_RESULT: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d = 1'b1;
          out_stat_d  = res_stat_q;
          out_val_d   = res_val_q;
          out_fpos_d  = res_fpos_q;
          out_len_d   = count_q;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      mode_q      <= CMP_EQUAL;
      pend_q      <= 1'b0;
      chk_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      pend_q      <= pend_d;
      chk_q       <= chk_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    pos_q      <= pos_d;
    val_q      <= val_d;
    idx_q      <= idx_d;
    addr_q     <= addr_d;
    waddr_q    <= waddr_d;
    cidx_q     <= cidx_d;
    res_stat_q <= res_stat_d;
    res_val_q  <= res_val_d;
    res_fpos_q <= res_fpos_d;
    out_stat_q <= out_stat_d;
    out_val_q  <= out_val_d;
    out_fpos_q <= out_fpos_d;
    out_len_q  <= out_len_d;
  end

  assign out_if.valid          = out_valid_q;
  assign out_if.status         = out_stat_q;
  assign out_if.value_out      = out_val_q;
  assign out_if.found_position = out_fpos_q;
  assign out_if.list_length    = out_len_q;

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the positional array list engine. A clocked driver
// pulls requests from a queue and a clocked monitor checks every result
// transfer against a shadow copy of the list kept inside the bench.
// ----------------------------------------------------------------------------
module tb_top import pale_pkg::*; ();

  // op code with no function in the block: must leave the list untouched
  localparam op_t OP_NONE = 3'd7;

  // worst-case walk over the whole list plus setup and output slack
  localparam int unsigned DRAIN_CYCLES = CAPACITY + 16;
  // long result-side hold-off, started once after HOLD_AT request transfers
  localparam int unsigned HOLD_AT      = 350;
  localparam int unsigned HOLD_CYCLES  = 400;
  // cycles without any transfer before the run is declared hung
  localparam int unsigned WATCHDOG_MAX = 4000;

  typedef struct {
    op_t   op;
    cnt_t  pos;
    data_t val;
  } list_req_t;

  typedef struct {
    stat_t status;
    data_t value;
    cnt_t  fpos;
    cnt_t  len;
  } list_result_t;

  logic  clk;
  logic  rst_n;
  logic  cfg_we;
  mode_t cfg_wdata;

  pale_in_if  req_ch ();
  pale_out_if rsp_ch ();

  positional_array_list_engine_unit i_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .in_if       (req_ch),
    .out_if      (rsp_ch),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata)
  );

  // --------------------------------------------------------------------------
  // Shadow list: the bench's own copy of the stored entries, the length and
  // the match rule. Only entries below shadow_len are ever read.
  // --------------------------------------------------------------------------
  data_t shadow_list [CAPACITY];
  cnt_t  shadow_len;
  mode_t shadow_mode;

  list_req_t    pending_ops[$];       // requests not yet offered
  list_result_t expected_results[$];  // results owed by the block, oldest first

  int unsigned mismatch_cnt;
  int unsigned req_xfers;
  bit          jitter_on;   // random idle bursts on both channels
  int unsigned hold_left;   // long hold-off on the result side
  bit          hold_done;

  // Apply one operation to the shadow list and return the result it owes.
  function automatic list_result_t apply_list_op(op_t op, cnt_t pos, data_t key);
    list_result_t r;
    int unsigned  n;
    int unsigned  p;
    int unsigned  k;
    bit           hit;
    r.status = STAT_OK;
    r.value  = '0;
    r.fpos   = '0;
    n = shadow_len;
    p = pos;
    case (op)
      OP_GET: begin
        if (p < 1 || p > n) r.status = STAT_BAD_POS;
        else r.value = shadow_list[p-1];
      end
      OP_INSERT: begin
        // position is checked ahead of fullness
        if (p < 1 || p > n + 1) begin
          r.status = STAT_BAD_POS;
        end else if (n >= CAPACITY) begin
          r.status = STAT_FULL;
        end else begin
          for (k = n; k >= p; k--) shadow_list[k] = shadow_list[k-1];
          shadow_list[p-1] = key;
          n++;
        end
      end
      OP_DELETE: begin
        if (p < 1 || p > n) begin
          r.status = STAT_BAD_POS;
        end else begin
          r.value = shadow_list[p-1];
          for (k = p; k < n; k++) shadow_list[k-1] = shadow_list[k];
          n--;
        end
      end
      OP_LOCATE: begin
        // first entry that satisfies the match rule; mode 3 acts as equal
        k   = 0;
        hit = 1'b0;
        while (!hit && k < n) begin
          case (shadow_mode)
            CMP_BELOW: hit = key < shadow_list[k];
            CMP_ABOVE: hit = key > shadow_list[k];
            default:   hit = key == shadow_list[k];
          endcase
          if (!hit) k++;
        end
        if (hit) r.fpos = cnt_t'(k + 1);
        else r.status = STAT_NOT_FOUND;
      end
      OP_PRIOR, OP_NEXT: begin
        // neighbor of the first equal entry; none at the list ends
        k = 0;
        while (k < n && shadow_list[k] != key) k++;
        if (op == OP_PRIOR) begin
          if (k < n && k > 0) r.value = shadow_list[k-1];
          else r.status = STAT_NOT_FOUND;
        end else begin
          if (k + 1 < n) r.value = shadow_list[k+1];
          else r.status = STAT_NOT_FOUND;
        end
      end
      OP_CLEAR: n = 0;
      default: ;
    endcase
    shadow_len = cnt_t'(n);
    r.len      = cnt_t'(n);
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Clock
  // --------------------------------------------------------------------------
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Request driver: takes the next queued request once the current one is
  // transferred. The shadow list is updated at the transfer edge, so the
  // expectation reflects exactly the order the block sees.
  // --------------------------------------------------------------------------
  int unsigned req_gap;

  always @(posedge clk) begin : req_driver
    list_req_t nxt;
    bit        fire;
    if (!rst_n) begin
      req_ch.valid    <= 1'b0;
      req_ch.op       <= OP_GET;
      req_ch.position <= '0;
      req_ch.value_in <= '0;
      req_gap         <= 0;
      req_xfers       <= 0;
    end else begin
      fire = req_ch.valid && req_ch.ready;
      if (fire) begin
        expected_results.push_back(
          apply_list_op(req_ch.op, req_ch.position, req_ch.value_in));
        req_xfers <= req_xfers + 1;
      end
      if (!req_ch.valid || fire) begin
        if (req_gap != 0) begin
          req_gap      <= req_gap - 1;
          req_ch.valid <= 1'b0;
        end else if (pending_ops.size() != 0 &&
                     !(jitter_on && $urandom_range(0, 6) == 0)) begin
          nxt = pending_ops.pop_front();
          req_ch.valid    <= 1'b1;
          req_ch.op       <= nxt.op;
          req_ch.position <= nxt.pos;
          req_ch.value_in <= nxt.val;
        end else begin
          // idle; with jitter on and requests queued, a random idle burst starts here
          req_ch.valid <= 1'b0;
          if (jitter_on && pending_ops.size() != 0) req_gap <= $urandom_range(0, 4);
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Long hold-off: once, the result side stops taking transfers for a long
  // stretch while requests keep coming, so the output register fills and the
  // block has to stall its request side.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin : long_hold
    if (!rst_n) begin
      hold_left <= 0;
      hold_done <= 1'b0;
    end else if (!hold_done && req_xfers == HOLD_AT) begin
      hold_left <= HOLD_CYCLES;
      hold_done <= 1'b1;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
    end
  end

  // --------------------------------------------------------------------------
  // Result monitor: every transfer is checked field by field against the
  // oldest expectation, then ready is chosen for the next cycle.
  // --------------------------------------------------------------------------
  int unsigned rsp_stall;

  always @(posedge clk) begin : rsp_monitor
    list_result_t want;
    if (!rst_n) begin
      rsp_ch.ready <= 1'b0;
      rsp_stall    <= 0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with nothing expected: status %0d value %h",
                 rsp_ch.status, rsp_ch.value_out);
          mismatch_cnt++;
        end else begin
          want = expected_results.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            mismatch_cnt++;
          end
          if (rsp_ch.value_out !== want.value) begin
            $error("value_out: expected %h, actual %h", want.value, rsp_ch.value_out);
            mismatch_cnt++;
          end
          if (rsp_ch.found_position !== want.fpos) begin
            $error("found_position: expected %0d, actual %0d",
                   want.fpos, rsp_ch.found_position);
            mismatch_cnt++;
          end
          if (rsp_ch.list_length !== want.len) begin
            $error("list_length: expected %0d, actual %0d",
                   want.len, rsp_ch.list_length);
            mismatch_cnt++;
          end
        end
      end
      if (hold_left != 0) begin
        rsp_ch.ready <= 1'b0;
      end else if (rsp_stall != 0) begin
        rsp_stall    <= rsp_stall - 1;
        rsp_ch.ready <= 1'b0;
      end else if (jitter_on && $urandom_range(0, 5) == 0) begin
        rsp_stall    <= $urandom_range(0, 4);
        rsp_ch.ready <= 1'b0;
      end else begin
        rsp_ch.ready <= 1'b1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Watchdog: too long without a transfer on either channel means a hang.
  // --------------------------------------------------------------------------
  int unsigned quiet_cycles;

  always @(posedge clk) begin : watchdog
    if (!rst_n) begin
      quiet_cycles <= 0;
    end else if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= WATCHDOG_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  task automatic push_op(op_t op, cnt_t pos, data_t val);
    list_req_t it;
    it.op  = op;
    it.pos = pos;
    it.val = val;
    pending_ops.push_back(it);
  endtask

  // Block drained: nothing queued, nothing offered, nothing owed, and the
  // sequencer given time to settle. Only then may the match rule change.
  task automatic write_compare_mode(mode_t mode);
    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= mode;
    shadow_mode = mode;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random requests shaped by the current shadow length: mostly legal
  // positions and keys taken from the list, with some out-of-range noise.
  // grow_w and shrink_w are percent weights for insert and delete; churn
  // allows the occasional clear and unused op.
  task automatic queue_random_ops(int unsigned count, int unsigned grow_w,
                                  int unsigned shrink_w, bit churn);
    list_req_t   it;
    int unsigned roll;
    int unsigned n;
    int unsigned upper;
    repeat (count) begin
      // keep the queue short so the shadow length stays close to the truth
      while (pending_ops.size() >= 2) @(negedge clk);
      n    = shadow_len;
      roll = $urandom_range(0, 99);
      if (roll < grow_w) it.op = OP_INSERT;
      else if (roll < grow_w + shrink_w) it.op = OP_DELETE;
      else if (churn && roll >= 98) it.op = (roll == 98) ? OP_CLEAR : OP_NONE;
      else begin
        case (roll % 4)
          0:       it.op = OP_GET;
          1:       it.op = OP_LOCATE;
          2:       it.op = OP_PRIOR;
          default: it.op = OP_NEXT;
        endcase
      end
      if ($urandom_range(0, 9) < 8) begin
        upper  = (it.op == OP_INSERT) ? n + 1 : n;
        it.pos = (upper != 0) ? cnt_t'($urandom_range(1, upper)) : '0;
      end else begin
        it.pos = cnt_t'($urandom_range(0, 127));
      end
      // small values repeat often, which exercises first-match rules
      case ($urandom_range(0, 3))
        0:       it.val = (n != 0) ? shadow_list[$urandom_range(0, n - 1)] : $urandom;
        1:       it.val = data_t'($urandom_range(0, 15));
        2:       it.val = $urandom_range(0, 1) ? '1 : 32'h8000_0000;
        default: it.val = $urandom;
      endcase
      pending_ops.push_back(it);
    end
  endtask

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    req_ch.valid    = 1'b0;
    req_ch.op       = OP_GET;
    req_ch.position = '0;
    req_ch.value_in = '0;
    rsp_ch.ready    = 1'b0;
    cfg_we          = 1'b0;
    cfg_wdata       = CMP_EQUAL;
    shadow_len      = '0;
    shadow_mode     = CMP_EQUAL;
    mismatch_cnt    = 0;
    jitter_on       = 1'b1;
    rst_n           = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, equal match rule from reset.
    // Empty list: every lookup misses, every position is out of range.
    push_op(OP_GET,    7'd1,   32'h0);
    push_op(OP_LOCATE, 7'd0,   32'h0);
    push_op(OP_PRIOR,  7'd0,   32'h0);
    push_op(OP_NEXT,   7'd0,   32'h0);
    push_op(OP_DELETE, 7'd1,   32'h0);
    push_op(OP_INSERT, 7'd0,   32'h5);
    push_op(OP_INSERT, 7'd2,   32'h5);
    // build [8000_0000, 0, FFFF_FFFF]
    push_op(OP_INSERT, 7'd1,   32'h0);
    push_op(OP_INSERT, 7'd2,   32'hFFFF_FFFF);
    push_op(OP_INSERT, 7'd1,   32'h8000_0000);
    push_op(OP_INSERT, 7'd127, 32'h1);
    push_op(OP_GET,    7'd3,   32'h0);
    push_op(OP_GET,    7'd4,   32'h0);
    push_op(OP_GET,    7'd127, 32'h0);
    push_op(OP_LOCATE, 7'd0,   32'h0);
    // no neighbor before the head or after the tail
    push_op(OP_PRIOR,  7'd0,   32'h8000_0000);
    push_op(OP_PRIOR,  7'd0,   32'h0);
    push_op(OP_NEXT,   7'd0,   32'hFFFF_FFFF);
    push_op(OP_NEXT,   7'd0,   32'h8000_0000);
    push_op(OP_LOCATE, 7'd0,   32'h1234_5678);
    push_op(OP_NONE,   7'd5,   32'hDEAD_BEEF);
    push_op(OP_DELETE, 7'd2,   32'h0);
    push_op(OP_DELETE, 7'd0,   32'h0);
    push_op(OP_CLEAR,  7'd0,   32'h0);
    push_op(OP_INSERT, 7'd1,   32'h5A5A_5A5A);

    // Random part: each phase under its own match rule.
    write_compare_mode(CMP_ABOVE);
    queue_random_ops(130, 55, 15, 1'b1);
    // fill to capacity, then keep inserting, mostly at legal positions
    write_compare_mode(CMP_BELOW);
    queue_random_ops(120, 95, 0, 1'b0);
    // unused mode must behave as equal; long hold-off lands in here
    write_compare_mode(mode_t'(3));
    queue_random_ops(150, 30, 30, 1'b1);
    write_compare_mode(CMP_EQUAL);
    queue_random_ops(150, 20, 55, 1'b1);
    // closing stretch at full rate on both sides
    write_compare_mode(CMP_ABOVE);
    jitter_on = 1'b0;
    queue_random_ops(130, 35, 30, 1'b1);

    while (pending_ops.size() != 0 || req_ch.valid || expected_results.size() != 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);

    if (mismatch_cnt == 0 && expected_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
